FILE: src/bss_pkg.sv
// Shared constants and types for the bounded stack with search.
// No dependencies; used by bounded_stack_with_search.
package bss_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OUT_CNT_W   = 8;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

endpackage

FILE: src/bounded_stack_with_search.sv
// Bounded LIFO stack of signed 32-bit words with search from the top.
// Depends on bss_pkg (depth, widths, mode and status codes, sequencer states).
//
// Usage: raise start with in_mode and in_operand_value while busy is low; the word is taken
// at that clock edge. Exactly one result follows, shown for a single cycle with out_strobe
// high; the receiver cannot stall it. Push, and any overflow, underflow or search on an empty
// stack, give their result in the cycle after the start cycle and leave busy low, so a new word
// may start right away. Pop and peek pass through the fetch state, since the top entry comes through the
// registered read port of the entry memory. Search walks down from the top entry: the sequencer
// reads one entry per cycle through the single memory read port and checks it with one shared
// 32-bit equality compare. For pop, peek and a search of a non-empty stack, busy is high from the
// cycle after the start cycle up to the cycle before the result, and low again while the result
// is shown, so a new word may start in that cycle. No clearing pass is needed after reset.
module bounded_stack_with_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic signed [31:0]           in_operand_value,
  output logic                         out_strobe,
  output logic [1:0]                   out_status,
  output logic signed [31:0]           out_result_value,
  output logic [7:0]                   out_position,
  output logic [7:0]                   out_fill_count
);

  localparam int unsigned AW = bss_pkg::ADDR_W;
  localparam int unsigned CW = bss_pkg::CNT_W;
  localparam int unsigned DW = bss_pkg::DATA_W;
  localparam int unsigned OW = bss_pkg::OUT_CNT_W;

  // Sequencer and stack state
  bss_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic             pop_r, pop_nxt;
  logic [DW-1:0]    operand_r, operand_nxt;

  // Result registers
  logic             strobe_r, strobe_nxt;
  bss_pkg::status_t status_r, status_nxt;
  logic [DW-1:0]    value_r, value_nxt;
  logic [OW-1:0]    position_r, position_nxt;

  // Entry memory, one write and one registered read port
  logic [DW-1:0]    entry_mem [bss_pkg::STACK_DEPTH];
  logic [DW-1:0]    rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CW-1:0]    count_m1;
  logic [AW-1:0]    top_addr;
  logic             hit;
  bss_pkg::mode_t   mode;

  assign busy     = (state_r != bss_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign mode     = bss_pkg::mode_t'(in_mode);
  assign full     = (count_r == CW'(bss_pkg::STACK_DEPTH));
  assign empty    = (count_r == '0);
  assign count_m1 = count_r - CW'(1);
  assign top_addr = count_m1[AW-1:0];
  assign wr_addr  = count_r[AW-1:0];
  // shared compare unit
  assign hit      = (rd_data_r == operand_r);

  // Sequence one word
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    pos_nxt      = pos_r;
    pop_nxt      = pop_r;
    operand_nxt  = operand_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    value_nxt    = value_r;
    position_nxt = position_r;
    wr_en        = 1'b0;
    rd_addr      = top_addr;

    case (state_r)
      bss_pkg::S_IDLE: begin
        if (accept) begin
          operand_nxt = in_operand_value;
          case (mode)
            bss_pkg::MODE_PUSH: begin
              strobe_nxt   = 1'b1;
              value_nxt    = '0;
              position_nxt = '0;
              if (full) begin
                status_nxt = bss_pkg::ST_OVERFLOW;
              end else begin
                status_nxt = bss_pkg::ST_OK;
                wr_en      = 1'b1;
                count_nxt  = count_r + CW'(1);
              end
            end
            bss_pkg::MODE_POP, bss_pkg::MODE_PEEK: begin
              if (empty) begin
                strobe_nxt   = 1'b1;
                status_nxt   = bss_pkg::ST_UNDERFLOW;
                value_nxt    = '0;
                position_nxt = '0;
              end else begin
                pop_nxt   = (mode == bss_pkg::MODE_POP);
                state_nxt = bss_pkg::S_FETCH;
              end
            end
            default: begin
              if (empty) begin
                strobe_nxt   = 1'b1;
                status_nxt   = bss_pkg::ST_NOT_FOUND;
                value_nxt    = '0;
                position_nxt = '0;
              end else begin
                addr_nxt  = top_addr;
                pos_nxt   = CW'(1);
                state_nxt = bss_pkg::S_SCAN;
              end
            end
          endcase
        end
      end
      bss_pkg::S_FETCH: begin
        // top entry is in the read register now
        strobe_nxt   = 1'b1;
        status_nxt   = bss_pkg::ST_OK;
        value_nxt    = rd_data_r;
        position_nxt = '0;
        if (pop_r) begin
          count_nxt = count_m1;
        end
        state_nxt = bss_pkg::S_IDLE;
      end
      bss_pkg::S_SCAN: begin
        rd_addr = addr_r - AW'(1);
        if (hit) begin
          strobe_nxt   = 1'b1;
          status_nxt   = bss_pkg::ST_OK;
          value_nxt    = '0;
          position_nxt = OW'(pos_r);
          state_nxt    = bss_pkg::S_IDLE;
        end else if (addr_r == '0) begin
          strobe_nxt   = 1'b1;
          status_nxt   = bss_pkg::ST_NOT_FOUND;
          value_nxt    = '0;
          position_nxt = '0;
          state_nxt    = bss_pkg::S_IDLE;
        end else begin
          // advance one entry toward the bottom
          addr_nxt = addr_r - AW'(1);
          pos_nxt  = pos_r + CW'(1);
        end
      end
      default: begin
        state_nxt = bss_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bss_pkg::S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    pos_r      <= pos_nxt;
    pop_r      <= pop_nxt;
    operand_r  <= operand_nxt;
    status_r   <= status_nxt;
    value_r    <= value_nxt;
    position_r <= position_nxt;
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= in_operand_value;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_result_value = value_r;
  assign out_position     = position_r;
  assign out_fill_count   = OW'(count_r);

  // Checks
  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !busy)
    else $error("result shown while sequencer busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(bss_pkg::STACK_DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == bss_pkg::MODE_PUSH && !full) |=>
      (count_r == $past(count_r) + CW'(1)) && strobe_r)
    else $error("push did not grow the stack");

  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bss_pkg::S_SCAN) |-> (pos_r != '0) && (pos_r <= count_r))
    else $error("search position out of range");

  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && position_r != '0) |->
      (status_r == bss_pkg::ST_OK) && (position_r <= OW'(count_r)))
    else $error("hit position beyond fill count");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_stack_with_search: directed corner cases and random traffic.
// Depends on bss_pkg and the bounded_stack_with_search top level; reads no files.
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * bss_pkg::STACK_DEPTH + 20;

  typedef struct packed {
    bss_pkg::status_t   status;
    logic signed [31:0] value;
    logic [7:0]         position;
    logic [7:0]         fill;
  } stack_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = bss_pkg::MODE_PUSH;
  logic signed [31:0] in_operand_value = '0;
  logic               out_strobe;
  logic [1:0]         out_status;
  logic signed [31:0] out_result_value;
  logic [7:0]         out_position;
  logic [7:0]         out_fill_count;

  // Stack shadow and the results it predicts, oldest first
  logic signed [31:0] stack_words [bss_pkg::STACK_DEPTH];
  int unsigned        stack_fill;
  stack_result_t      expected_results [$];

  int unsigned        idle_pct;
  int unsigned        mismatch_count;
  int unsigned        cycle_count;

  bounded_stack_with_search i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_operand_value (in_operand_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_position     (out_position),
    .out_fill_count   (out_fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow stack and return the result it must give
  task automatic stack_apply(input bss_pkg::mode_t op, input logic signed [31:0] word,
                             output stack_result_t r);
    r = '{status: bss_pkg::ST_OK, value: '0, position: '0, fill: '0};
    case (op)
      bss_pkg::MODE_PUSH: begin
        if (stack_fill >= bss_pkg::STACK_DEPTH) begin
          r.status = bss_pkg::ST_OVERFLOW;
        end else begin
          stack_words[stack_fill] = word;
          stack_fill++;
        end
      end
      bss_pkg::MODE_POP: begin
        if (stack_fill == 0) begin
          r.status = bss_pkg::ST_UNDERFLOW;
        end else begin
          stack_fill--;
          r.value = stack_words[stack_fill];
        end
      end
      bss_pkg::MODE_PEEK: begin
        if (stack_fill == 0) r.status = bss_pkg::ST_UNDERFLOW;
        else r.value = stack_words[stack_fill - 1];
      end
      default: begin
        // Walk down from the top; the nearest equal word wins
        r.status = bss_pkg::ST_NOT_FOUND;
        for (int k = 0; k < stack_fill; k++) begin
          if (stack_words[stack_fill - 1 - k] == word) begin
            r.status   = bss_pkg::ST_OK;
            r.position = 8'(k + 1);
            break;
          end
        end
      end
    endcase
    r.fill = 8'(stack_fill);
  endtask

  // Present one word after a random idle gap; hold it until taken, then record its result
  task automatic send_word(input bss_pkg::mode_t op, input logic signed [31:0] word);
    stack_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_mode          <= op;
    in_operand_value <= word;
    do @(posedge clk); while (busy);
    stack_apply(op, word, r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Mix a few special words with full-width random ones
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return 32'(signed'($urandom_range(3)));
      default: return $urandom;
    endcase
  endfunction

  // Search key: mostly a word held somewhere in the stack, else a fresh one
  function automatic logic signed [31:0] pick_key();
    if (stack_fill != 0 && $urandom_range(9) < 7) return stack_words[$urandom_range(stack_fill - 1)];
    return pick_word();
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    stack_result_t e;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d value %0d pos %0d fill %0d",
                 $time, out_status, out_result_value, out_position, out_fill_count);
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_status != e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          mismatch_count++;
        end
        if (out_result_value != e.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time, e.value,
                   out_result_value);
          mismatch_count++;
        end
        if (out_position != e.position) begin
          $display("%0t: position expected %0d actual %0d", $time, e.position, out_position);
          mismatch_count++;
        end
        if (out_fill_count != e.fill) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, e.fill, out_fill_count);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bounded_stack_with_search] ERROR");
      $finish;
    end
  end

  // Underflow and not-found on an empty stack
  task automatic test_empty_ops();
    send_word(bss_pkg::MODE_POP, 32'sd0);
    send_word(bss_pkg::MODE_PEEK, -32'sd1);
    send_word(bss_pkg::MODE_SEARCH, 32'sd0);
    send_word(bss_pkg::MODE_SEARCH, 32'sh8000_0000);
  endtask

  // Extreme words go in and come back intact
  task automatic test_extreme_words();
    send_word(bss_pkg::MODE_PUSH, 32'sh8000_0000);
    send_word(bss_pkg::MODE_PUSH, 32'sh7fff_ffff);
    send_word(bss_pkg::MODE_PUSH, -32'sd1);
    send_word(bss_pkg::MODE_PUSH, 32'sd0);
    send_word(bss_pkg::MODE_PEEK, 32'sd0);
    send_word(bss_pkg::MODE_SEARCH, 32'sh8000_0000);
    send_word(bss_pkg::MODE_SEARCH, -32'sd1);
    send_word(bss_pkg::MODE_SEARCH, 32'sd12345);
    repeat (4) send_word(bss_pkg::MODE_POP, 32'sh7fff_ffff);
    send_word(bss_pkg::MODE_POP, 32'sd0);
  endtask

  // Duplicates: the copy nearest the top is reported
  task automatic test_search_order();
    send_word(bss_pkg::MODE_PUSH, 32'sd5);
    send_word(bss_pkg::MODE_PUSH, 32'sd9);
    send_word(bss_pkg::MODE_PUSH, 32'sd5);
    send_word(bss_pkg::MODE_SEARCH, 32'sd5);
    send_word(bss_pkg::MODE_POP, 32'sd0);
    send_word(bss_pkg::MODE_SEARCH, 32'sd5);
    send_word(bss_pkg::MODE_POP, 32'sd0);
    send_word(bss_pkg::MODE_POP, 32'sd0);
  endtask

  // Random runs: fill to overflow, drain to underflow, search bursts and mixed traffic
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned    sent;
    int unsigned    run_len;
    bss_pkg::mode_t op;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(9))
        0: begin
          while (stack_fill < bss_pkg::STACK_DEPTH) begin
            send_word(bss_pkg::MODE_PUSH, ($urandom_range(3) == 0) ? pick_word() : $urandom);
            sent++;
          end
          repeat ($urandom_range(1, 2)) send_word(bss_pkg::MODE_PUSH, pick_word());
          send_word(bss_pkg::MODE_SEARCH, stack_words[0]);
          send_word(bss_pkg::MODE_PEEK, pick_word());
          sent += 4;
        end
        1: begin
          while (stack_fill != 0) begin
            send_word(bss_pkg::MODE_POP, pick_word());
            sent++;
          end
          send_word(bss_pkg::MODE_POP, pick_word());
          send_word(bss_pkg::MODE_PEEK, pick_word());
          send_word(bss_pkg::MODE_SEARCH, pick_word());
          sent += 3;
        end
        2, 3, 4: begin
          run_len = $urandom_range(2, 6);
          repeat (run_len) send_word(bss_pkg::MODE_SEARCH, pick_key());
          sent += run_len;
        end
        default: begin
          run_len = $urandom_range(4, 16);
          repeat (run_len) begin
            op = bss_pkg::mode_t'($urandom_range(3));
            // Lean toward push while the stack is shallow
            if (stack_fill < bss_pkg::STACK_DEPTH / 4 && $urandom_range(1) == 0) begin
              op = bss_pkg::MODE_PUSH;
            end
            send_word(op, (op == bss_pkg::MODE_SEARCH) ? pick_key() : pick_word());
          end
          sent += run_len;
        end
      endcase
    end
  endtask

  initial begin
    stack_fill     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_pct       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_ops();
    test_extreme_words();
    test_search_order();

    // Back-to-back, then a mostly idle sender, then a lightly idle one
    idle_pct = 0;
    test_random_traffic(200);
    idle_pct = 79;
    test_random_traffic(125);
    idle_pct = 26;
    test_random_traffic(125);

    // Drain outstanding results, then allow for a late stray strobe
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[bounded_stack_with_search] OK");
    end else begin
      $display("[bounded_stack_with_search] ERROR");
    end
    $finish;
  end

endmodule
